FILE: src/bitset_with_rank_query_assert.svh
// assertion macros for the bitset with rank query block
// expects clk_i and rst_ni in the scope of every use
`ifndef BITSET_WITH_RANK_QUERY_ASSERT_SVH
`define BITSET_WITH_RANK_QUERY_ASSERT_SVH

// checked outside reset only
`define BRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/brq_pkg.sv
// types, constants and the popcount function of the bitset with rank query block
// no dependencies
package brq_pkg;

  localparam int NumBits  = 1024;
  localparam int WordBits = 64;   // power of two
  localparam int NumWords = (NumBits + WordBits - 1) / WordBits;
  localparam int WordIdxW = $clog2(NumWords);
  localparam int WalkW    = $clog2(NumWords + 1);
  localparam int BitIdxW  = $clog2(WordBits);
  localparam int TallyW   = $clog2(WordBits + 1);
  localparam int KindW    = 3;
  localparam int IndexW   = 11;
  localparam int RankW    = 11;

  typedef enum logic [KindW-1:0] {
    KindClear     = 3'd0,
    KindSet       = 3'd1,
    KindReset     = 3'd2,
    KindRead      = 3'd3,
    KindRank      = 3'd4,
    KindRankIfSet = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StWalk,
    StPart
  } state_e;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [TallyW-1:0]   tally_t;

  // adder tree, one level per halving
  function automatic tally_t pop_count(word_t v);
    tally_t s [WordBits];
    for (int i = 0; i < WordBits; i++) begin
      s[i] = tally_t'(v[i]);
    end
    for (int step = 1; step < WordBits; step = step * 2) begin
      for (int i = 0; i + step < WordBits; i = i + 2 * step) begin
        s[i] = s[i] + s[i + step];
      end
    end
    return s[0];
  endfunction

endpackage

FILE: src/bitset_with_rank_query.sv
// bitset with per-word set-bit tallies and rank queries, top level
// depends on brq_pkg and bitset_with_rank_query_assert.svh
//
// one word per start: kind_i and index_i are taken at a rising edge with start_i high and
// busy_o low. clear all, set, reset, read, bad kinds and absent ranks end in the exec
// state; other ranks go on through the walk and part states, since the sum of whole words
// goes through one adder that takes one word tally per cycle, and the part state adds the
// masked popcount of the partial word. the result is shown for exactly one cycle with
// valid_o high, in the first cycle with busy_o low; it cannot be held off, so capture it
// then. a new start may be given in that same cycle. bit_value_o is the indexed bit
// before the operation (0 for clear all), rank_o the set bits strictly below index_i,
// absent_o flags a bad kind, an index out of range (above 1024 for rank, 1024 and up
// otherwise) or a rank if set on a clear bit. the bit store and tallies reset to zero.
`include "bitset_with_rank_query_assert.svh"

module bitset_with_rank_query (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [brq_pkg::KindW-1:0]   kind_i,
  input  logic [brq_pkg::IndexW-1:0]  index_i,
  output logic                        busy_o,
  output logic                        valid_o,
  output logic                        bit_value_o,
  output logic [brq_pkg::RankW-1:0]   rank_o,
  output logic                        absent_o
);
  import brq_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // captured command word
  logic [KindW-1:0]  kind_q, kind_d;
  logic [IndexW-1:0] index_q, index_d;

  // bit store and per-word tallies, flops so clear all and reset can zero every word at once
  word_t  words_q [NumWords];
  word_t  words_d [NumWords];
  tally_t tallies_q [NumWords];
  tally_t tallies_d [NumWords];

  // tally walk: word counter and running sum
  logic [WalkW-1:0] walk_q, walk_d;
  logic [RankW-1:0] sum_q, sum_d;
  logic             cur_q, cur_d;

  // result registers
  logic             valid_q, valid_d;
  logic             bit_value_q, bit_value_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic             absent_q, absent_d;

  // index decode
  logic [IndexW-1:0]   word_sel_full;
  logic [WordIdxW-1:0] word_sel;
  logic [BitIdxW-1:0]  bit_sel;
  logic                in_range;
  logic                rank_ok;
  word_t               sel_word;
  word_t               bit_mask;
  word_t               part_mask;
  logic                cur;
  logic [WalkW-1:0]    walk_lim;
  tally_t              part_cnt;
  tally_t              walk_tally;
  logic                go_walk;

  assign word_sel_full = IndexW'(index_q / WordBits);
  assign word_sel      = word_sel_full[WordIdxW-1:0];
  assign bit_sel       = BitIdxW'(index_q % WordBits);
  assign in_range      = index_q < IndexW'(NumBits);
  assign rank_ok       = index_q <= IndexW'(NumBits);
  assign sel_word      = words_q[word_sel];
  assign bit_mask      = word_t'(1) << bit_sel;
  assign part_mask     = bit_mask - word_t'(1);
  assign cur           = in_range & sel_word[bit_sel];
  // whole words below the index; at most all words for a valid rank
  assign walk_lim      = WalkW'(word_sel_full);
  assign part_cnt      = pop_count(sel_word & part_mask);
  assign walk_tally    = tallies_q[walk_q[WordIdxW-1:0]];

  // rank kinds that go on to the tally walk
  assign go_walk = ((kind_q == KindRank) && rank_ok) ||
                   ((kind_q == KindRankIfSet) && cur);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = go_walk ? StWalk : StIdle;
      end
      StWalk: begin
        if (walk_q == walk_lim) begin
          state_d = StPart;
        end
      end
      StPart: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    kind_d      = kind_q;
    index_d     = index_q;
    words_d     = words_q;
    tallies_d   = tallies_q;
    walk_d      = walk_q;
    sum_d       = sum_q;
    cur_d       = cur_q;
    valid_d     = 1'b0;
    bit_value_d = bit_value_q;
    rank_d      = rank_q;
    absent_d    = absent_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          kind_d  = kind_i;
          index_d = index_i;
        end
      end
      StExec: begin
        walk_d      = '0;
        sum_d       = '0;
        cur_d       = cur;
        // default result: bad word, nothing changes
        valid_d     = !go_walk;
        bit_value_d = 1'b0;
        rank_d      = '0;
        absent_d    = 1'b1;
        case (kind_q)
          KindClear: begin
            for (int w = 0; w < NumWords; w++) begin
              words_d[w]   = '0;
              tallies_d[w] = '0;
            end
            absent_d = 1'b0;
          end
          KindSet: begin
            if (in_range) begin
              bit_value_d = cur;
              absent_d    = 1'b0;
              if (!cur) begin
                words_d[word_sel]   = sel_word | bit_mask;
                tallies_d[word_sel] = tally_t'(tallies_q[word_sel] + 1'b1);
              end
            end
          end
          KindReset: begin
            if (in_range) begin
              bit_value_d = cur;
              absent_d    = 1'b0;
              if (cur) begin
                words_d[word_sel]   = sel_word & ~bit_mask;
                tallies_d[word_sel] = tally_t'(tallies_q[word_sel] - 1'b1);
              end
            end
          end
          KindRead: begin
            if (in_range) begin
              bit_value_d = cur;
              absent_d    = 1'b0;
            end
          end
          KindRank, KindRankIfSet: begin
            // out of range or clear bit keeps the default; else the walk follows
          end
          default: begin
          end
        endcase
      end
      StWalk: begin
        if (walk_q != walk_lim) begin
          sum_d  = sum_q + RankW'(walk_tally);
          walk_d = walk_q + 1'b1;
        end
      end
      StPart: begin
        valid_d     = 1'b1;
        bit_value_d = cur_q;
        rank_d      = sum_q + (in_range ? RankW'(part_cnt) : RankW'(0));
        absent_d    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state and store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= 1'b0;
      words_q   <= '{default: '0};
      tallies_q <= '{default: '0};
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      words_q   <= words_d;
      tallies_q <= tallies_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    index_q     <= index_d;
    walk_q      <= walk_d;
    sum_q       <= sum_d;
    cur_q       <= cur_d;
    bit_value_q <= bit_value_d;
    rank_q      <= rank_d;
    absent_q    <= absent_d;
  end

  assign busy_o      = state_q != StIdle;
  assign valid_o     = valid_q;
  assign bit_value_o = bit_value_q;
  assign rank_o      = rank_q;
  assign absent_o    = absent_q;

  `BRQ_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted word did not raise busy")
  `BRQ_ASSERT_ALWAYS(a_valid_pulse, valid_o |=> !valid_o, "result strobe longer than one cycle")
  `BRQ_ASSERT(a_absent_clean, (valid_o && absent_o) |-> (rank_o == '0 && !bit_value_o), "absent result carries data")
  `BRQ_ASSERT(a_rank_bound, valid_o |-> (rank_o <= RankW'(NumBits)), "rank above vector size")
  `BRQ_ASSERT(a_tally_exact, (state_q == StIdle) |-> (tallies_q[0] == pop_count(words_q[0])), "word tally out of step")
  `BRQ_ASSERT_ALWAYS(a_walk_bound, (state_q == StWalk) |-> (walk_q <= walk_lim), "tally walk overran")

endmodule

FILE: tb/sv/testbench.sv
// testbench for bitset_with_rank_query: directed corner words, then random bursts
// depends on brq_pkg and the bitset_with_rank_query rtl
`timescale 1ns / 100ps

module testbench;
  import brq_pkg::*;

  // kinds the block must reject, outside kind_e
  localparam logic [KindW-1:0] KindBadLo = 3'd6;
  localparam logic [KindW-1:0] KindBadHi = 3'd7;

  localparam int RandomWords = 1450;
  localparam int CycleLimit  = 400_000;
  localparam int DrainCycles = 25;

  // one answer of the block, as it shows on the result ports
  typedef struct packed {
    logic             bit_value;
    logic [RankW-1:0] rank;
    logic             absent;
  } answer_t;

  // scoreboard: shadow bitset with tallies and a queue of answers still due
  class rank_scoreboard;
    word_t   words [NumWords];
    tally_t  tallies [NumWords];
    answer_t answers_due [$];
    int      errors;
    int      checked;

    function new();
      foreach (words[w]) begin
        words[w]   = '0;
        tallies[w] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // set bits strictly below idx: whole-word tallies, then the partial word
    function logic [RankW-1:0] count_below(int unsigned idx);
      int unsigned wi;
      int unsigned b;
      int unsigned sum;
      wi  = idx / WordBits;
      b   = idx % WordBits;
      sum = 0;
      for (int w = 0; w < wi && w < NumWords; w++) begin
        sum += tallies[w];
      end
      if (b != 0 && wi < NumWords) begin
        sum += $countones(words[wi] & ((word_t'(1) << b) - word_t'(1)));
      end
      return sum[RankW-1:0];
    endfunction

    // an accepted word: update the shadow state and queue its answer
    function void note_word(logic [KindW-1:0] kind, logic [IndexW-1:0] index);
      answer_t     a;
      int unsigned w;
      int unsigned b;
      logic        in_range;
      logic        cur;
      a        = '0;
      w        = index / WordBits;
      b        = index % WordBits;
      in_range = index < NumBits;
      cur      = in_range ? words[w][b] : 1'b0;
      case (kind)
        KindClear: begin
          foreach (words[i]) begin
            words[i]   = '0;
            tallies[i] = '0;
          end
          cur = 1'b0;
        end
        KindSet: begin
          if (!in_range) begin
            a.absent = 1'b1;
          end else if (!cur) begin
            words[w][b] = 1'b1;
            tallies[w]  = tallies[w] + 1'b1;
          end
        end
        KindReset: begin
          if (!in_range) begin
            a.absent = 1'b1;
          end else if (cur) begin
            words[w][b] = 1'b0;
            tallies[w]  = tallies[w] - 1'b1;
          end
        end
        KindRead: begin
          if (!in_range) a.absent = 1'b1;
        end
        KindRank: begin
          // index of NumBits is legal here and gives the total
          if (index > NumBits) a.absent = 1'b1;
          else a.rank = count_below(index);
        end
        KindRankIfSet: begin
          if (!in_range || !cur) a.absent = 1'b1;
          else a.rank = count_below(index);
        end
        default: begin
          a.absent = 1'b1;
          cur      = 1'b0;
        end
      endcase
      a.bit_value = cur;
      answers_due.push_back(a);
    endfunction

    task check_result(logic bit_value, logic [RankW-1:0] rank, logic absent);
      answer_t e;
      checked++;
      if (answers_due.size() == 0) begin
        report("result with no word outstanding");
        return;
      end
      e = answers_due.pop_front();
      if (bit_value !== e.bit_value)
        report($sformatf("bit_value %b, wanted %b", bit_value, e.bit_value));
      if (rank !== e.rank)
        report($sformatf("rank %0d, wanted %0d", rank, e.rank));
      if (absent !== e.absent)
        report($sformatf("absent %b, wanted %b", absent, e.absent));
    endtask

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [KindW-1:0]   kind_i = '0;
  logic [IndexW-1:0]  index_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic               bit_value_o;
  logic [RankW-1:0]   rank_o;
  logic               absent_o;

  rank_scoreboard sb = new();
  int             kind_count [8];
  int             cycles = 0;

  bitset_with_rank_query u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .kind_i      (kind_i),
    .index_i     (index_i),
    .busy_o      (busy_o),
    .valid_o     (valid_o),
    .bit_value_o (bit_value_o),
    .rank_o      (rank_o),
    .absent_o    (absent_o)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // watchdog, sized well above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d answers still due", cycles, sb.pending());
      $display("** bitset_with_rank_query: FAILED **");
      $finish;
    end
  end

  // monitor: outputs are sampled before this edge's updates land
  // the result is checked first, since a word accepted on the same edge is a later one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(bit_value_o, rank_o, absent_o);
      if (start_i && !busy_o) begin
        sb.note_word(kind_i, index_i);
        kind_count[kind_i]++;
      end
    end
  end

  // present one word and hold it until the block takes it
  // called at a rising edge; returns at the edge that accepted the word, start_i still high
  task automatic send_word(input logic [KindW-1:0] kind, input logic [IndexW-1:0] index);
    start_i <= 1'b1;
    kind_i  <= kind;
    index_i <= index;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // idle gap on the sender side; a zero gap leaves start_i alone
  task automatic pause(input int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    kind_i  <= KindBadHi;
    index_i <= IndexW'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       set_hist [$];
    int unsigned       hot_word;
    int unsigned       burst_left;
    int unsigned       r;
    int unsigned       pick;
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] index;

    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: store starts empty
    send_word(KindRead, 11'd0);
    send_word(KindRank, 11'd0);
    send_word(KindRank, 11'(NumBits));
    // first and last bit of a word, the next word, the very last bit
    send_word(KindSet, 11'd0);
    send_word(KindSet, 11'd63);
    send_word(KindSet, 11'd64);
    send_word(KindSet, 11'(NumBits - 1));
    send_word(KindSet, 11'd63);                 // already set, tally must not move
    send_word(KindRead, 11'(NumBits - 1));
    send_word(KindRank, 11'd63);                // partial word only
    send_word(KindRank, 11'd64);                // one whole word, no partial
    send_word(KindRank, 11'd65);
    send_word(KindRank, 11'(NumBits));          // total count
    send_word(KindRankIfSet, 11'(NumBits - 1));
    send_word(KindRankIfSet, 11'd500);          // bit clear, flagged absent
    // index out of range for each kind that takes one
    send_word(KindSet, 11'(NumBits));
    send_word(KindReset, 11'(NumBits));
    send_word(KindRead, 11'(NumBits));
    send_word(KindRankIfSet, 11'(NumBits));
    send_word(KindRank, 11'(NumBits + 1));
    send_word(KindRank, 11'h7ff);
    send_word(KindBadLo, 11'd0);
    send_word(KindBadHi, 11'd64);
    send_word(KindReset, 11'd63);
    send_word(KindReset, 11'd63);               // already clear
    send_word(KindClear, 11'h7ff);              // index ignored
    send_word(KindRank, 11'(NumBits));
    pause($urandom_range(1, 8));

    // random part: bursts of words with random gaps, sets dominate so the store fills
    hot_word   = $urandom_range(0, NumWords - 1);
    burst_left = 0;
    for (int n = 0; n < RandomWords; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        // about a quarter of bursts follow the previous one with no gap
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
      end
      burst_left--;

      r = $urandom_range(0, 999);
      if (r < 3) kind = KindClear;
      else if (r < 430) kind = KindSet;
      else if (r < 580) kind = KindReset;
      else if (r < 680) kind = KindRead;
      else if (r < 830) kind = KindRank;
      else if (r < 975) kind = KindRankIfSet;
      else kind = (r < 988) ? KindBadLo : KindBadHi;

      if ($urandom_range(0, 19) == 0) hot_word = $urandom_range(0, NumWords - 1);

      // index mix: uniform, a hot word to fill tallies, recently set bits,
      // word edges, the rank-only index and out of range
      pick = $urandom_range(0, 99);
      if (pick < 40) index = 11'($urandom_range(0, NumBits - 1));
      else if (pick < 62) index = 11'(hot_word * WordBits + $urandom_range(0, WordBits - 1));
      else if (pick < 82 && set_hist.size() != 0)
        index = 11'(set_hist[$urandom_range(0, set_hist.size() - 1)]);
      else if (pick < 90)
        index = 11'($urandom_range(0, NumWords - 1) * WordBits
                     + ($urandom_range(0, 1) ? WordBits - 1 : 0));
      else if (pick < 95) index = 11'(NumBits);
      else index = 11'($urandom_range(NumBits + 1, 2047));

      if (kind == KindSet && index < NumBits) begin
        set_hist.push_back(index);
        if (set_hist.size() > 64) void'(set_hist.pop_front());
      end
      send_word(kind, index);
    end
    pause(1);

    // drain, then allow for the latency of one more word
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("words sent: %0d clear, %0d set, %0d reset, %0d read, %0d rank, %0d rank-if-set, %0d bad",
             kind_count[KindClear], kind_count[KindSet], kind_count[KindReset],
             kind_count[KindRead], kind_count[KindRank], kind_count[KindRankIfSet],
             kind_count[KindBadLo] + kind_count[KindBadHi]);
    $display("results checked: %0d, mismatches: %0d, cycles: %0d",
             sb.checked, sb.errors, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** bitset_with_rank_query: PASSED **");
    end else begin
      $display("** bitset_with_rank_query: FAILED **");
    end
    $finish;
  end

endmodule

FILE: bitset_with_rank_query.f
+incdir+src
src/brq_pkg.sv
src/bitset_with_rank_query.sv
tb/sv/testbench.sv
